@@ sv/ars_pkg.sv @@
// Shared types and codes for the alert repeat scheduler.
package ars_pkg;

   typedef logic [2:0] event_code_type;
   localparam event_code_type EV_RAISE  = 3'd0;
   localparam event_code_type EV_CANCEL = 3'd1;
   localparam event_code_type EV_POLL   = 3'd2;
   localparam event_code_type EV_SENT   = 3'd3;
   localparam event_code_type EV_INIT   = 3'd4;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_OFF        = 2'd0;
   localparam mode_type MODE_HELP       = 2'd1;
   localparam mode_type MODE_CANCELLING = 2'd2;

   localparam logic KIND_HELP   = 1'b0;
   localparam logic KIND_CANCEL = 1'b1;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_REPEAT_INTERVAL = 2'd0;
   localparam csr_index_type CSR_CANCEL_REPEATS  = 2'd1;

   localparam logic [15:0] REPEAT_INTERVAL_RESET = 16'd1000;
   localparam logic [7:0]  CANCEL_REPEATS_RESET  = 8'd3;

   typedef struct packed {
      logic [15:0] repeat_interval_ms;
      logic [7:0]  cancel_repeats;
   } cfg_type;

   typedef struct packed {
      event_code_type req_type;
      logic [31:0]    now_ms;
      logic [7:0]     load_epoch;
   } req_item_type;

   typedef struct packed {
      logic        accepted;
      logic        due;
      logic        alert_kind;
      logic [7:0]  alert_epoch;
      logic [7:0]  repeat_count;
      mode_type    mode_now;
      logic        armed_flag;
   } rsp_item_type;

endpackage

@@ sv/ars_if.sv @@
// Valid/ready channel interfaces for event requests and results.
interface ars_req_if;
   logic                    valid;
   logic                    ready;
   ars_pkg::event_code_type req_type;
   logic [31:0]             now_ms;
   logic [7:0]              load_epoch;

   modport source (output valid, output req_type, output now_ms, output load_epoch,
                   input ready);
   modport sink (input valid, input req_type, input now_ms, input load_epoch,
                 output ready);
endinterface

interface ars_rsp_if;
   logic              valid;
   logic              ready;
   logic              accepted;
   logic              due;
   logic              alert_kind;
   logic [7:0]        alert_epoch;
   logic [7:0]        repeat_count;
   ars_pkg::mode_type mode_now;
   logic              armed_flag;

   modport source (output valid, output accepted, output due, output alert_kind,
                   output alert_epoch, output repeat_count, output mode_now,
                   output armed_flag, input ready);
   modport sink (input valid, input accepted, input due, input alert_kind,
                 input alert_epoch, input repeat_count, input mode_now,
                 input armed_flag, output ready);
endinterface

@@ sv/ars_csr.sv @@
// Configuration registers: repeat interval and cancel send count.
module ars_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  ars_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_wdata,
   output ars_pkg::cfg_type       cfg
);

   ars_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.repeat_interval_ms <= ars_pkg::REPEAT_INTERVAL_RESET;
         cfg_ff.cancel_repeats     <= ars_pkg::CANCEL_REPEATS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ars_pkg::CSR_REPEAT_INTERVAL: cfg_ff.repeat_interval_ms <= csr_wdata;
            ars_pkg::CSR_CANCEL_REPEATS:  cfg_ff.cancel_repeats <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/ars_engine.sv @@
// Scheduler state and the per-event next-state and result logic.
module ars_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  ars_pkg::req_item_type item,
   input  ars_pkg::cfg_type      cfg,
   output ars_pkg::rsp_item_type result
);

   ars_pkg::mode_type mode_ff, mode_in;
   logic [7:0]        epoch_ff, epoch_in;
   logic [7:0]        repeat_ff, repeat_in;
   logic [31:0]       next_send_ff, next_send_in;
   logic [7:0]        cancels_ff, cancels_in;
   logic              armed_ff, armed_in;
   logic [31:0]       delta;
   logic [7:0]        cancels_dec;

   assign delta       = item.now_ms - next_send_ff;
   assign cancels_dec = cancels_ff - 8'd1;

   always_comb begin
      mode_in      = mode_ff;
      epoch_in     = epoch_ff;
      repeat_in    = repeat_ff;
      next_send_in = next_send_ff;
      cancels_in   = cancels_ff;
      armed_in     = armed_ff;
      result       = '0;
      unique case (item.req_type)
         ars_pkg::EV_RAISE: begin
            if (mode_ff != ars_pkg::MODE_HELP) begin
               epoch_in        = epoch_ff + 8'd1;
               repeat_in       = 8'd0;
               mode_in         = ars_pkg::MODE_HELP;
               next_send_in    = item.now_ms;
               armed_in        = 1'b1;
               result.accepted = 1'b1;
            end
         end
         ars_pkg::EV_CANCEL: begin
            if (mode_ff == ars_pkg::MODE_HELP) begin
               mode_in      = ars_pkg::MODE_CANCELLING;
               cancels_in   = cfg.cancel_repeats;
               repeat_in    = 8'd0;
               next_send_in = item.now_ms;
               armed_in     = 1'b1;
            end
         end
         ars_pkg::EV_POLL: begin
            if (mode_ff == ars_pkg::MODE_OFF) begin
               armed_in = 1'b0;
            end else begin
               result.due = ~delta[31];
               armed_in   = ~delta[31];
               if (!delta[31]) begin
                  result.alert_kind   = (mode_ff == ars_pkg::MODE_HELP) ?
                                        ars_pkg::KIND_HELP : ars_pkg::KIND_CANCEL;
                  result.alert_epoch  = epoch_ff;
                  result.repeat_count = repeat_ff;
               end
            end
         end
         ars_pkg::EV_SENT: begin
            repeat_in    = repeat_ff + 8'd1;
            next_send_in = item.now_ms + {16'd0, cfg.repeat_interval_ms};
            if (mode_ff == ars_pkg::MODE_CANCELLING) begin
               cancels_in = cancels_dec;
               if (cancels_dec == 8'd0) begin
                  mode_in = ars_pkg::MODE_OFF;
               end
            end
         end
         ars_pkg::EV_INIT: begin
            mode_in      = ars_pkg::MODE_OFF;
            epoch_in     = item.load_epoch;
            repeat_in    = 8'd0;
            next_send_in = 32'd0;
            cancels_in   = 8'd0;
            armed_in     = 1'b0;
         end
         default: ;
      endcase
      result.mode_now   = mode_in;
      result.armed_flag = armed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= ars_pkg::MODE_OFF;
         epoch_ff     <= 8'd0;
         repeat_ff    <= 8'd0;
         next_send_ff <= 32'd0;
         cancels_ff   <= 8'd0;
         armed_ff     <= 1'b0;
      end else if (fire) begin
         mode_ff      <= mode_in;
         epoch_ff     <= epoch_in;
         repeat_ff    <= repeat_in;
         next_send_ff <= next_send_in;
         cancels_ff   <= cancels_in;
         armed_ff     <= armed_in;
      end
   end

   a_raise_enters_help: assert property (@(posedge clock) disable iff (reset)
      fire && item.req_type == ars_pkg::EV_RAISE && mode_ff != ars_pkg::MODE_HELP
      |=> mode_ff == ars_pkg::MODE_HELP && armed_ff && repeat_ff == 8'd0)
      else $error("raise did not enter help");

   a_init_loads_epoch: assert property (@(posedge clock) disable iff (reset)
      fire && item.req_type == ars_pkg::EV_INIT
      |=> mode_ff == ars_pkg::MODE_OFF && epoch_ff == $past(item.load_epoch) && !armed_ff)
      else $error("init did not load epoch");

   a_sent_bumps_repeat: assert property (@(posedge clock) disable iff (reset)
      fire && item.req_type == ars_pkg::EV_SENT |=> repeat_ff == $past(repeat_ff) + 8'd1)
      else $error("sent did not advance repeat count");

   a_idle_holds_state: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(mode_ff) && $stable(epoch_ff) && $stable(next_send_ff))
      else $error("state changed without a transfer");

endmodule

@@ sv/alert_repeat_scheduler.sv @@
// Top level: input register, scheduler engine, result register.
// A request is held in the input register until the result register is free.
// Throughput: one event per cycle unless results stall; engine state updates
// as an event moves from the input register into the result register.
// Reset (synchronous, active high) empties both registers, sets the mode to
// off with all counters zero, interval 1000 ms and three cancel sends.
module alert_repeat_scheduler (
   input  logic                   clock,
   input  logic                   reset,
   ars_req_if.sink                req_chan,
   ars_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  ars_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_wdata
);

   ars_pkg::cfg_type      cfg;
   ars_pkg::req_item_type item_ff;
   ars_pkg::rsp_item_type result;
   ars_pkg::rsp_item_type rsp_ff;
   logic                  item_valid_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_free;
   logic                  advance;

   assign rsp_free       = ~rsp_valid_ff | rsp_chan.ready;
   assign advance        = item_valid_ff & rsp_free;
   assign req_chan.ready = ~item_valid_ff | advance;

   ars_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ars_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         item_valid_ff <= req_chan.valid;
      end
      if (req_chan.valid && req_chan.ready) begin
         item_ff.req_type   <= req_chan.req_type;
         item_ff.now_ms     <= req_chan.now_ms;
         item_ff.load_epoch <= req_chan.load_epoch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= item_valid_ff;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.accepted     = rsp_ff.accepted;
   assign rsp_chan.due          = rsp_ff.due;
   assign rsp_chan.alert_kind   = rsp_ff.alert_kind;
   assign rsp_chan.alert_epoch  = rsp_ff.alert_epoch;
   assign rsp_chan.repeat_count = rsp_ff.repeat_count;
   assign rsp_chan.mode_now     = rsp_ff.mode_now;
   assign rsp_chan.armed_flag   = rsp_ff.armed_flag;

endmodule
